// ===== rtl/le_pkg.sv =====
// Package for the line editor: key codes, action codes, result type.
// No dependencies; used by le_out_reg, the top level, the checker and the testbench.
package le_pkg;

	localparam int LINE_WIDTH_DEF = 40;

	localparam logic [7:0] KEY_DELETE = 8'h7F;
	localparam logic [7:0] KEY_KILL   = 8'h15;
	localparam logic [7:0] KEY_WORD   = 8'h17;
	localparam logic [7:0] KEY_EOT    = 8'h04;
	localparam logic [7:0] KEY_CR     = 8'h0D;
	localparam logic [7:0] KEY_LF     = 8'h0A;
	localparam logic [7:0] KEY_SPACE  = 8'h20;
	localparam logic [7:0] KEY_TILDE  = 8'h7E;

	localparam logic [2:0] ACT_ECHO    = 3'd0;
	localparam logic [2:0] ACT_ERASE   = 3'd1;
	localparam logic [2:0] ACT_CLEAR   = 3'd2;
	localparam logic [2:0] ACT_NEWLINE = 3'd3;
	localparam logic [2:0] ACT_BELL    = 3'd4;
	localparam logic [2:0] ACT_EXIT    = 3'd5;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] echo_char;
		logic       last_of_run;
	} act_res_t;

endpackage

// ===== rtl/le_if.sv =====
// Valid/ready channels of the line editor: keystroke in, display action out.
// No dependencies.
interface le_key_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_byte;
	modport source (output valid, output key_byte, input ready);
	modport sink (input valid, input key_byte, output ready);
endinterface

interface le_act_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] echo_char;
	logic       last_of_run;
	modport source (output valid, output action, output echo_char, output last_of_run,
		input ready);
	modport sink (input valid, input action, input echo_char, input last_of_run,
		output ready);
endinterface

// ===== rtl/le_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module le_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 41
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/le_out_reg.sv =====
// One-entry output register that drives the action channel.
// Depends on le_pkg and le_if.
module le_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  le_pkg::act_res_t din,
	output logic            can_push,
	le_act_if.source        act
);
	import le_pkg::*;

	logic     valid_q;
	act_res_t data_q;

	assign can_push = !valid_q || act.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (act.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= din;
		end
	end

	assign act.valid       = valid_q;
	assign act.action      = data_q.action;
	assign act.echo_char   = data_q.echo_char;
	assign act.last_of_run = data_q.last_of_run;
endmodule

// ===== rtl/line_editor_with_word_wrap.sv =====
// Line editor top level: keystroke sequencer around the line RAM.
// Depends on le_pkg, le_if, le_ram and le_out_reg.
//
// Usage: keystroke items enter on the key channel (valid/ready), display
// actions leave on the act channel, one action per item, the final action of
// a keystroke marked by last_of_run. A keystroke may cause no action at all.
// Keys are handled one at a time. A simple key is accepted, then decoded and
// emitted. Ctrl-U emits one erase per character, and Ctrl-W reads each
// character from the line RAM before it erases it. A wrapping keystroke reads
// the line entry by entry: the line RAM has one read port and every entry is
// read in one state and used in the next one (boundary scan, echo of the kept
// part, move of the carried word).
// The key channel is ready whenever the sequencer is idle, also while the
// last action still waits in the output register. A stalled receiver holds
// the sequencer at its next action. After reset the line is empty and the
// editor runs; after an exit action every key is taken and dropped until
// reset. The line RAM needs no clearing: only written entries are read.
module line_editor_with_word_wrap #(
	parameter int LINE_WIDTH = le_pkg::LINE_WIDTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	le_key_if.sink   key,
	le_act_if.source act
);
	import le_pkg::*;

	localparam int DEPTH = LINE_WIDTH + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(LINE_WIDTH + 2);
	localparam logic [CW-1:0] LW_C  = CW'(LINE_WIDTH);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;
	localparam logic [3:0] S_KILL   = 4'd2;
	localparam logic [3:0] S_W_RD   = 4'd3;
	localparam logic [3:0] S_W_CHK  = 4'd4;
	localparam logic [3:0] S_W_FIN  = 4'd5;
	localparam logic [3:0] S_WS_RD  = 4'd6;
	localparam logic [3:0] S_WS_CHK = 4'd7;
	localparam logic [3:0] S_CLR    = 4'd8;
	localparam logic [3:0] S_E_RD   = 4'd9;
	localparam logic [3:0] S_E_EMIT = 4'd10;
	localparam logic [3:0] S_NL     = 4'd11;
	localparam logic [3:0] S_C_RD   = 4'd12;
	localparam logic [3:0] S_C_WR   = 4'd13;

	logic [3:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] start_q, start_d;
	logic [7:0]    key_q, key_d;
	logic          halted_q, halted_d;
	logic          phase_q, phase_d;
	logic          pend_q, pend_d;

	logic          push, can_push;
	act_res_t      res;
	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rd_data;
	logic [CW-1:0] carry_len;
	logic          is_print, rd_space;

	assign key.ready = (state_q == S_IDLE);
	assign carry_len = cnt_q - start_q;
	assign is_print  = (key_q >= KEY_SPACE) && (key_q <= KEY_TILDE);
	assign rd_space  = (rd_data == KEY_SPACE);

	le_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rd_data)
	);

	le_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din      (res),
		.can_push (can_push),
		.act      (act)
	);

	// Reads and writes of one entry never fall in the same cycle, so no forwarding is needed.
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		idx_d    = idx_q;
		start_d  = start_q;
		key_d    = key_q;
		halted_d = halted_q;
		phase_d  = phase_q;
		pend_d   = pend_q;
		push     = 1'b0;
		res      = '0;
		we       = 1'b0;
		waddr    = '0;
		wdata    = key_q;
		re       = 1'b0;
		raddr    = '0;
		case (state_q)
			S_IDLE: begin
				if (key.valid && !halted_q) begin
					key_d   = key.key_byte;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (key_q == KEY_EOT && cnt_q == '0) begin
					if (can_push) begin
						push     = 1'b1;
						res      = '{action: ACT_EXIT, echo_char: 8'h00, last_of_run: 1'b1};
						halted_d = 1'b1;
						state_d  = S_IDLE;
					end
				end else if (key_q == KEY_DELETE && cnt_q != '0) begin
					if (can_push) begin
						push    = 1'b1;
						res     = '{action: ACT_ERASE, echo_char: 8'h00, last_of_run: 1'b1};
						cnt_d   = cnt_q - ONE_C;
						state_d = S_IDLE;
					end
				end else if (key_q == KEY_KILL) begin
					state_d = S_KILL;
				end else if (key_q == KEY_WORD) begin
					phase_d = 1'b0;
					pend_d  = 1'b0;
					state_d = S_W_RD;
				end else if (key_q == KEY_CR || key_q == KEY_LF) begin
					if (can_push) begin
						push    = 1'b1;
						res     = '{action: ACT_NEWLINE, echo_char: 8'h00, last_of_run: 1'b1};
						cnt_d   = '0;
						state_d = S_IDLE;
					end
				end else if (is_print) begin
					if (cnt_q < LW_C) begin
						if (can_push) begin
							we      = 1'b1;
							waddr   = cnt_q[AW-1:0];
							push    = 1'b1;
							res     = '{action: ACT_ECHO, echo_char: key_q, last_of_run: 1'b1};
							cnt_d   = cnt_q + ONE_C;
							state_d = S_IDLE;
						end
					end else begin
						we      = 1'b1;
						waddr   = LW_C[AW-1:0];
						cnt_d   = LW_C + ONE_C;
						idx_d   = LW_C + ONE_C;
						state_d = S_WS_RD;
					end
				end else begin
					if (can_push) begin
						push    = 1'b1;
						res     = '{action: ACT_BELL, echo_char: 8'h00, last_of_run: 1'b1};
						state_d = S_IDLE;
					end
				end
			end
			S_KILL: begin
				if (cnt_q == '0) begin
					state_d = S_IDLE;
				end else if (can_push) begin
					push = 1'b1;
					res  = '{action: ACT_ERASE, echo_char: 8'h00,
						last_of_run: (cnt_q == ONE_C)};
					cnt_d = cnt_q - ONE_C;
					if (cnt_q == ONE_C) begin
						state_d = S_IDLE;
					end
				end
			end
			S_W_RD: begin
				if (cnt_q == '0) begin
					state_d = S_W_FIN;
				end else begin
					re      = 1'b1;
					raddr   = AW'(cnt_q - ONE_C);
					state_d = S_W_CHK;
				end
			end
			S_W_CHK: begin
				// first trailing spaces, then the word; an erase is held back
				// until the next decision tells whether it ends the run
				if (!phase_q && !rd_space) begin
					phase_d = 1'b1;
				end else if (phase_q && rd_space) begin
					state_d = S_W_FIN;
				end else if (!pend_q || can_push) begin
					push    = pend_q;
					res     = '{action: ACT_ERASE, echo_char: 8'h00, last_of_run: 1'b0};
					pend_d  = 1'b1;
					cnt_d   = cnt_q - ONE_C;
					state_d = S_W_RD;
				end
			end
			S_W_FIN: begin
				if (!pend_q) begin
					state_d = S_IDLE;
				end else if (can_push) begin
					push    = 1'b1;
					res     = '{action: ACT_ERASE, echo_char: 8'h00, last_of_run: 1'b1};
					pend_d  = 1'b0;
					state_d = S_IDLE;
				end
			end
			S_WS_RD: begin
				if (idx_q == '0) begin
					start_d = LW_C;
					state_d = S_CLR;
				end else begin
					re      = 1'b1;
					raddr   = AW'(idx_q - ONE_C);
					state_d = S_WS_CHK;
				end
			end
			S_WS_CHK: begin
				if (rd_space) begin
					start_d = idx_q;
					state_d = S_CLR;
				end else begin
					idx_d   = idx_q - ONE_C;
					state_d = S_WS_RD;
				end
			end
			S_CLR: begin
				if (can_push) begin
					push    = 1'b1;
					res     = '{action: ACT_CLEAR, echo_char: 8'h00, last_of_run: 1'b0};
					idx_d   = '0;
					state_d = S_E_RD;
				end
			end
			S_E_RD: begin
				if (idx_q == start_q) begin
					state_d = S_NL;
				end else begin
					re      = 1'b1;
					raddr   = idx_q[AW-1:0];
					state_d = S_E_EMIT;
				end
			end
			S_E_EMIT: begin
				if (can_push) begin
					push    = 1'b1;
					res     = '{action: ACT_ECHO, echo_char: rd_data, last_of_run: 1'b0};
					idx_d   = idx_q + ONE_C;
					state_d = S_E_RD;
				end
			end
			S_NL: begin
				if (can_push) begin
					push  = 1'b1;
					res   = '{action: ACT_NEWLINE, echo_char: 8'h00,
						last_of_run: (carry_len == '0)};
					idx_d = '0;
					if (carry_len == '0) begin
						cnt_d   = '0;
						state_d = S_IDLE;
					end else begin
						state_d = S_C_RD;
					end
				end
			end
			S_C_RD: begin
				re      = 1'b1;
				raddr   = AW'(start_q + idx_q);
				state_d = S_C_WR;
			end
			S_C_WR: begin
				if (can_push) begin
					we    = 1'b1;
					waddr = idx_q[AW-1:0];
					wdata = rd_data;
					push  = 1'b1;
					res   = '{action: ACT_ECHO, echo_char: rd_data,
						last_of_run: (idx_q == carry_len - ONE_C)};
					idx_d = idx_q + ONE_C;
					if (idx_q == carry_len - ONE_C) begin
						cnt_d   = carry_len;
						state_d = S_IDLE;
					end else begin
						state_d = S_C_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			halted_q <= 1'b0;
			phase_q  <= 1'b0;
			pend_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			halted_q <= halted_d;
			phase_q  <= phase_d;
			pend_q   <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		start_q <= start_d;
		key_q   <= key_d;
	end

	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> cnt_q <= LW_C)
		else $error("line count above width while idle");

	a_exit_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(push && res.action == ACT_EXIT) |=> halted_q)
		else $error("exit action without halt");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !push)
		else $error("action produced while halted");

	a_wrap_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> (cnt_q == LW_C + ONE_C && start_q != '0))
		else $error("wrap started with bad line state");
endmodule

// ===== tb/sv/line_echo_checker.sv =====
`timescale 1ns / 1ps
// Checker for the line editor: watches the key and action channels, predicts
// the display actions of every accepted keystroke and compares them in order.
// Depends on le_pkg and le_if.
module line_echo_checker #(
	parameter int LINE_WIDTH = le_pkg::LINE_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	le_key_if    key,
	le_act_if    act,
	output int   fails,
	output int   pending
);
	import le_pkg::*;

	logic [7:0] line_buf [0:LINE_WIDTH];
	int         line_len;
	bit         halted;
	act_res_t   expected_acts [$];
	int         act_count;

	function automatic act_res_t mk_act(input logic [2:0] a, input logic [7:0] c);
		act_res_t r;
		r.action      = a;
		r.echo_char   = c;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	function automatic void predict_echo(input logic [7:0] k);
		act_res_t   run [$];
		int         start;
		int         carry_len;
		if (halted)
			return;
		if (k == KEY_EOT && line_len == 0) begin
			run.push_back(mk_act(ACT_EXIT, 8'h00));
			halted = 1'b1;
		end else if (k == KEY_DELETE && line_len > 0) begin
			line_len--;
			run.push_back(mk_act(ACT_ERASE, 8'h00));
		end else if (k == KEY_KILL) begin
			while (line_len > 0) begin
				line_len--;
				run.push_back(mk_act(ACT_ERASE, 8'h00));
			end
		end else if (k == KEY_WORD) begin
			while (line_len > 0 && line_buf[line_len - 1] == KEY_SPACE) begin
				line_len--;
				run.push_back(mk_act(ACT_ERASE, 8'h00));
			end
			while (line_len > 0 && line_buf[line_len - 1] != KEY_SPACE) begin
				line_len--;
				run.push_back(mk_act(ACT_ERASE, 8'h00));
			end
		end else if (k == KEY_CR || k == KEY_LF) begin
			run.push_back(mk_act(ACT_NEWLINE, 8'h00));
			line_len = 0;
		end else if (k >= KEY_SPACE && k <= KEY_TILDE) begin
			if (line_len < LINE_WIDTH) begin
				line_buf[line_len] = k;
				line_len++;
				run.push_back(mk_act(ACT_ECHO, k));
			end else begin
				// overflow: redraw through the last space, carry the tail word
				line_buf[LINE_WIDTH] = k;
				line_len = LINE_WIDTH + 1;
				start = line_len;
				while (start > 0 && line_buf[start - 1] != KEY_SPACE)
					start--;
				if (start == 0)
					start = LINE_WIDTH;
				carry_len = line_len - start;
				run.push_back(mk_act(ACT_CLEAR, 8'h00));
				for (int i = 0; i < start; i++)
					run.push_back(mk_act(ACT_ECHO, line_buf[i]));
				run.push_back(mk_act(ACT_NEWLINE, 8'h00));
				for (int i = 0; i < carry_len; i++) begin
					line_buf[i] = line_buf[start + i];
					run.push_back(mk_act(ACT_ECHO, line_buf[i]));
				end
				line_len = carry_len;
			end
		end else begin
			run.push_back(mk_act(ACT_BELL, 8'h00));
		end
		if (run.size() > 0)
			run[run.size() - 1].last_of_run = 1'b1;
		foreach (run[i])
			expected_acts.push_back(run[i]);
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		$display("[%0t] action %0d: %s got %h want %h", $time, act_count, what, got, want);
		fails++;
	endtask

	task automatic check_action();
		act_res_t want;
		act_count++;
		if (expected_acts.size() == 0) begin
			report_mismatch("unexpected action", {5'd0, act.action}, 8'h00);
			return;
		end
		want = expected_acts.pop_front();
		if (act.action !== want.action)
			report_mismatch("action", {5'd0, act.action}, {5'd0, want.action});
		if (act.echo_char !== want.echo_char)
			report_mismatch("echo_char", act.echo_char, want.echo_char);
		if (act.last_of_run !== want.last_of_run)
			report_mismatch("last_of_run", {7'd0, act.last_of_run}, {7'd0, want.last_of_run});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= LINE_WIDTH; i++)
				line_buf[i] = 8'h00;
			line_len  = 0;
			halted    = 1'b0;
			act_count = 0;
			expected_acts.delete();
			pending = 0;
		end else begin
			if (key.valid && key.ready)
				predict_echo(key.key_byte);
			if (act.valid && act.ready)
				check_action();
			pending = expected_acts.size();
		end
	end

endmodule

// ===== tb/sv/tb_line_editor_with_word_wrap.sv =====
`timescale 1ns / 1ps
// Testbench top for the line editor: clock, reset, keystroke stimulus and
// action-channel backpressure; the verdict comes from line_echo_checker.
// Depends on le_pkg, le_if, line_editor_with_word_wrap and line_echo_checker.
module tb_line_editor_with_word_wrap;
	import le_pkg::*;

	localparam int LINE_WIDTH  = LINE_WIDTH_DEF;
	localparam int KEY_TARGET  = 450;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending_acts;
	int   keys_sent;
	int   cycle_count;
	bit   idle_on;
	bit   hold_long;

	le_key_if key_ch ();
	le_act_if act_ch ();

	line_editor_with_word_wrap #(.LINE_WIDTH(LINE_WIDTH)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (key_ch),
		.act    (act_ch)
	);

	line_echo_checker #(.LINE_WIDTH(LINE_WIDTH)) i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.key     (key_ch),
		.act     (act_ch),
		.fails   (fail_count),
		.pending (pending_acts)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// leaves valid high after the handshake; the caller sends again or lowers it
	task automatic send_key(input logic [7:0] b);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			key_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		key_ch.valid    <= 1'b1;
		key_ch.key_byte <= b;
		@(posedge clk);
		while (!key_ch.ready)
			@(posedge clk);
		keys_sent++;
	endtask

	// action receiver
	initial begin
		act_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_long) begin
				act_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_long = 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				act_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				act_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [7:0] drill [$];
		logic [7:0] b;
		int         pick;
		int         len;
		bit         nospace;
		bit         hold_done;
		bit         pause_done;

		arst_n          = 1'b0;
		cycle_count     = 0;
		keys_sent       = 0;
		idle_on         = 1'b1;
		hold_long       = 1'b0;
		hold_done       = 1'b0;
		pause_done      = 1'b0;
		key_ch.valid    <= 1'b0;
		key_ch.key_byte <= 8'h00;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// edge keys, empty-line controls, Ctrl-D on a non-empty line, word erase
		drill = '{8'h00, 8'hFF, 8'h80, 8'h1F, KEY_KILL, KEY_WORD, KEY_DELETE,
			KEY_SPACE, KEY_TILDE, 8'h21, KEY_EOT, KEY_SPACE, KEY_SPACE, KEY_WORD,
			KEY_DELETE, 8'h41, 8'h42, KEY_KILL, 8'h43, KEY_CR, 8'h44, KEY_LF};
		foreach (drill[i])
			send_key(drill[i]);

		while (keys_sent < KEY_TARGET) begin
			if (!hold_done && keys_sent >= 150) begin
				hold_long = 1'b1;
				hold_done = 1'b1;
			end
			if (!pause_done && keys_sent >= 300) begin
				key_ch.valid <= 1'b0;
				@(posedge clk);
				wait (pending_acts == 0);
				pause_done = 1'b1;
			end
			if (keys_sent >= 380)
				idle_on = 1'b0;
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 45) : $urandom_range(1, 8);
				repeat (len) send_key(8'($urandom_range(8'h21, 8'h7E)));
				repeat ($urandom_range(0, 2)) send_key(KEY_SPACE);
			end else if (pick < 64) begin
				// fill a fresh line to the edge, then overflow it
				send_key(KEY_CR);
				nospace = ($urandom_range(0, 2) == 0);
				repeat (LINE_WIDTH)
					send_key((!nospace && $urandom_range(0, 5) == 0) ? KEY_SPACE :
						8'($urandom_range(8'h21, 8'h7E)));
				send_key($urandom_range(0, 1) ? KEY_SPACE : 8'($urandom_range(8'h21, 8'h7E)));
			end else if (pick < 72) begin
				send_key(KEY_DELETE);
			end else if (pick < 77) begin
				send_key(KEY_WORD);
			end else if (pick < 80) begin
				send_key(KEY_KILL);
			end else if (pick < 86) begin
				send_key($urandom_range(0, 1) ? KEY_CR : KEY_LF);
			end else begin
				b = 8'($urandom_range(0, 255));
				if (b == KEY_EOT)
					b = 8'h00;
				send_key(b);
			end
		end

		// exit, then keys that the halted editor drops
		send_key(KEY_CR);
		send_key(KEY_EOT);
		repeat (6) send_key(8'($urandom_range(0, 255)));
		key_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending_acts == 0);
		repeat (200) @(posedge clk);

		if (fail_count == 0 && pending_acts == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== line_editor_with_word_wrap.f =====
rtl/le_pkg.sv
rtl/le_if.sv
rtl/le_ram.sv
rtl/le_out_reg.sv
rtl/line_editor_with_word_wrap.sv
tb/sv/line_echo_checker.sv
tb/sv/tb_line_editor_with_word_wrap.sv
